/* src/packet_slot_ring_buffer_assert.svh */
// Assertion macros shared by the packet slot ring buffer RTL.
`ifndef PACKET_SLOT_RING_BUFFER_ASSERT_SVH
`define PACKET_SLOT_RING_BUFFER_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define PSRB_ASSERT_ALWAYS(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("psrb: invariant violated");

// Consequent must hold in the cycle after the antecedent.
`define PSRB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("psrb: sequence check failed");

`endif

/* src/psrb_pkg.sv */
// Package with types and constants of the packet slot ring buffer.
`timescale 1ns / 1ps

package psrb_pkg;

    localparam int SLOT_BYTES_DEFAULT = 200;
    localparam int MAX_SLOTS_DEFAULT  = 16;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 5;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_OVERSIZE = 2'd3
    } status_t;

    typedef struct packed {
        logic              operation;
        logic [BYTE_W-1:0] data_byte;
        logic              last;
    } psrb_in_t;

    typedef struct packed {
        status_t           status;
        logic [BYTE_W-1:0] read_byte;
        logic [IDX_W-1:0]  slot_index;
        logic              packet_done;
        logic [CNT_W-1:0]  occupancy;
    } psrb_out_t;

endpackage

/* src/psrb_slot_store.sv */
// Byte store of all packet slots: one write port, one registered read port.
`timescale 1ns / 1ps

module psrb_slot_store #(
    parameter int SLOT_BYTES = psrb_pkg::SLOT_BYTES_DEFAULT,
    parameter int MAX_SLOTS  = psrb_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                                         aclk,
    input  logic                                         wr_en,
    input  logic [$clog2(SLOT_BYTES*MAX_SLOTS)-1:0]      wr_addr,
    input  logic [psrb_pkg::BYTE_W-1:0]                  wr_data,
    input  logic                                         rd_en,
    input  logic [$clog2(SLOT_BYTES*MAX_SLOTS)-1:0]      rd_addr,
    output logic [psrb_pkg::BYTE_W-1:0]                  rd_data
);

    localparam int DEPTH = SLOT_BYTES * MAX_SLOTS;

    logic [psrb_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [psrb_pkg::BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read register only moves on a read, so it holds while the item waits downstream.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/packet_slot_ring_buffer.sv */
// Top level of the packet slot ring buffer: ring control, fill counts and output stages.
`timescale 1ns / 1ps
`include "packet_slot_ring_buffer_assert.svh"

// Channel  Ports                          Direction  Payload
// s_       s_valid, s_ready, s_item       in         operation, data_byte, last
// m_       m_valid, m_ready, m_item       out        status, read_byte, slot_index,
//                                                    packet_done, occupancy
// cfg_     cfg_wr_en, cfg_wr_data         in         ring_slots
//
// One item is accepted per cycle while s_ready is high; its result passes through the
// store read register and the output register.
// Each slot keeps a fill count of the bytes written by its packet; bytes past it read
// as zero, so the store itself needs no clearing pass after reset or a ring_slots write.
// A stalled result holds the output register; one more item may then sit in the
// store read stage before s_ready drops.

module packet_slot_ring_buffer #(
    parameter int SLOT_BYTES = psrb_pkg::SLOT_BYTES_DEFAULT,
    parameter int MAX_SLOTS  = psrb_pkg::MAX_SLOTS_DEFAULT
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  psrb_pkg::psrb_in_t          s_item,
    output logic                        m_valid,
    input  logic                        m_ready,
    output psrb_pkg::psrb_out_t         m_item,
    input  logic                        cfg_wr_en,
    input  logic [psrb_pkg::CFG_W-1:0]  cfg_wr_data
);

    localparam int OFF_W  = $clog2(SLOT_BYTES + 1);
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int ADDR_W = $clog2(SLOT_BYTES * MAX_SLOTS);
    localparam int CFG_W  = psrb_pkg::CFG_W;

    typedef struct packed {
        psrb_pkg::status_t            status;
        logic [psrb_pkg::IDX_W-1:0]   slot_index;
        logic                         packet_done;
        logic [psrb_pkg::CNT_W-1:0]   occupancy;
        logic                         use_store;
    } stage_t;

    logic [CFG_W-1:0]           eff_slots_reg;
    logic [SLOT_W-1:0]          front_reg, front_next;
    logic [SLOT_W-1:0]          rear_reg, rear_next;
    logic [psrb_pkg::CNT_W-1:0] count_reg, count_next;
    logic [OFF_W-1:0]           wr_off_reg, wr_off_next;
    logic [OFF_W-1:0]           rd_off_reg, rd_off_next;
    logic                       rejected_reg, rejected_next;
    logic [OFF_W-1:0]           fill_reg [MAX_SLOTS];

    logic                       s1_valid_reg;
    stage_t                     s1_reg, s1_next;
    logic                       m_valid_reg;
    psrb_pkg::psrb_out_t        m_item_reg;

    logic                       accept;
    logic                       s1_advance;
    logic [CFG_W-1:0]           cfg_clamped;
    logic [SLOT_W-1:0]          rear_wrap;
    logic [SLOT_W-1:0]          front_wrap;
    logic [OFF_W-1:0]           rd_off_inc;

    logic                       st_wr_en;
    logic [ADDR_W-1:0]          st_wr_addr;
    logic                       st_rd_en;
    logic [ADDR_W-1:0]          st_rd_addr;
    logic [psrb_pkg::BYTE_W-1:0] st_rd_data;

    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W-1:0] s,
                                                    input logic [CFG_W-1:0]  n);
        logic [CFG_W-1:0] inc;
        inc = CFG_W'(s) + CFG_W'(1);
        return (inc == n) ? '0 : SLOT_W'(inc);
    endfunction

    assign accept     = s_valid && s_ready;
    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;

    assign rear_wrap  = wrap_slot(rear_reg, eff_slots_reg);
    assign front_wrap = wrap_slot(front_reg, eff_slots_reg);
    assign rd_off_inc = rd_off_reg + OFF_W'(1);

    always_comb begin
        if (cfg_wr_data < CFG_W'(2)) begin
            cfg_clamped = CFG_W'(2);
        end else if (cfg_wr_data > CFG_W'(MAX_SLOTS)) begin
            cfg_clamped = CFG_W'(MAX_SLOTS);
        end else begin
            cfg_clamped = cfg_wr_data;
        end
    end

    assign st_wr_addr = ADDR_W'(rear_reg) * ADDR_W'(SLOT_BYTES) + ADDR_W'(wr_off_reg);
    assign st_rd_addr = ADDR_W'(front_reg) * ADDR_W'(SLOT_BYTES) + ADDR_W'(rd_off_reg);

    always_comb begin
        front_next    = front_reg;
        rear_next     = rear_reg;
        count_next    = count_reg;
        wr_off_next   = wr_off_reg;
        rd_off_next   = rd_off_reg;
        rejected_next = rejected_reg;
        st_wr_en      = 1'b0;
        st_rd_en      = 1'b0;
        s1_next       = '{status: psrb_pkg::STATUS_OK, slot_index: '0, packet_done: 1'b0,
                          occupancy: count_reg, use_store: 1'b0};

        if (accept) begin
            if (s_item.operation == psrb_pkg::OP_WRITE) begin
                if (rejected_reg) begin
                    s1_next.status = psrb_pkg::STATUS_FULL;
                    if (s_item.last) begin
                        rejected_next = 1'b0;
                    end
                end else if (wr_off_reg == '0 && rear_wrap == front_reg) begin
                    // The full check is made only when a packet opens.
                    s1_next.status = psrb_pkg::STATUS_FULL;
                    if (!s_item.last) begin
                        rejected_next = 1'b1;
                    end
                end else begin
                    if (wr_off_reg < OFF_W'(SLOT_BYTES)) begin
                        st_wr_en    = 1'b1;
                        wr_off_next = wr_off_reg + OFF_W'(1);
                    end else begin
                        s1_next.status = psrb_pkg::STATUS_OVERSIZE;
                    end
                    if (s_item.last) begin
                        rear_next           = rear_wrap;
                        count_next          = count_reg + psrb_pkg::CNT_W'(1);
                        wr_off_next         = '0;
                        s1_next.slot_index  = psrb_pkg::IDX_W'(rear_wrap);
                        s1_next.packet_done = 1'b1;
                    end
                end
            end else begin
                if (front_reg == rear_reg) begin
                    s1_next.status = psrb_pkg::STATUS_EMPTY;
                end else begin
                    st_rd_en          = 1'b1;
                    // Bytes past the packet's fill count are not taken from the store and read as zero.
                    s1_next.use_store = rd_off_reg < fill_reg[front_reg];
                    rd_off_next       = rd_off_inc;
                    if (rd_off_inc == OFF_W'(SLOT_BYTES)) begin
                        s1_next.slot_index  = psrb_pkg::IDX_W'(front_reg);
                        s1_next.packet_done = 1'b1;
                        front_next          = front_wrap;
                        count_next          = count_reg - psrb_pkg::CNT_W'(1);
                        rd_off_next         = '0;
                    end
                end
            end
        end
        s1_next.occupancy = count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_slots_reg <= CFG_W'(MAX_SLOTS);
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            wr_off_reg    <= '0;
            rd_off_reg    <= '0;
            rejected_reg  <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                fill_reg[i] <= '0;
            end
        end else if (cfg_wr_en) begin
            eff_slots_reg <= cfg_clamped;
            front_reg     <= '0;
            rear_reg      <= '0;
            count_reg     <= '0;
            wr_off_reg    <= '0;
            rd_off_reg    <= '0;
            rejected_reg  <= 1'b0;
            for (int i = 0; i < MAX_SLOTS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            front_reg    <= front_next;
            rear_reg     <= rear_next;
            count_reg    <= count_next;
            wr_off_reg   <= wr_off_next;
            rd_off_reg   <= rd_off_next;
            rejected_reg <= rejected_next;
            if (st_wr_en) begin
                fill_reg[rear_reg] <= wr_off_reg + OFF_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
        if (s1_advance) begin
            m_item_reg.status      <= s1_reg.status;
            m_item_reg.read_byte   <= s1_reg.use_store ? st_rd_data : '0;
            m_item_reg.slot_index  <= s1_reg.slot_index;
            m_item_reg.packet_done <= s1_reg.packet_done;
            m_item_reg.occupancy   <= s1_reg.occupancy;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    psrb_slot_store #(
        .SLOT_BYTES (SLOT_BYTES),
        .MAX_SLOTS  (MAX_SLOTS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (s_item.data_byte),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    `PSRB_ASSERT_ALWAYS(a_count_bound, aclk, aresetn, CFG_W'(count_reg) < eff_slots_reg)
    `PSRB_ASSERT_ALWAYS(a_empty_match, aclk, aresetn, (front_reg == rear_reg) == (count_reg == '0))
    `PSRB_ASSERT_ALWAYS(a_rd_off_range, aclk, aresetn, rd_off_reg < OFF_W'(SLOT_BYTES))
    `PSRB_ASSERT_ALWAYS(a_wr_off_range, aclk, aresetn, wr_off_reg <= OFF_W'(SLOT_BYTES))
    `PSRB_ASSERT_NEXT(a_stage_hold, aclk, aresetn, s1_valid_reg && !s1_advance, s1_valid_reg)

endmodule
